// ===== src/drfw_pkg.sv =====
package drfw_pkg;

  // Ring geometry. Both sizes are powers of two of at most 2^24 bytes.
  localparam int unsigned RING0_BYTES  = 2097152;
  localparam int unsigned RING1_BYTES  = 16777216;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned ROOM_MARGIN  = 128;
  localparam int unsigned ALIGN_ADD    = 3;

  localparam int unsigned OFF_W  = 24;
  localparam int unsigned HEAD_W = 32;
  localparam int unsigned LEN_W  = 16;

  localparam logic [OFF_W-1:0] R0_WRAP = OFF_W'(RING0_BYTES - 1);
  localparam logic [OFF_W-1:0] R1_WRAP = OFF_W'(RING1_BYTES - 1);

  // Command queue between the front and the back.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef enum logic {
    CMD_HDR  = 1'b0,
    CMD_BYTE = 1'b1
  } cmd_kind_t;

  typedef enum logic [1:0] {
    RK_BYTE = 2'd0,
    RK_WORD = 2'd1,
    RK_PUB  = 2'd2
  } rkind_t;

  // One unit of back-end work: a header run or one payload byte with an
  // optional head publish.
  typedef struct packed {
    cmd_kind_t         kind;
    logic              dual;
    logic              pub;
    logic [OFF_W-1:0]  off0;
    logic [OFF_W-1:0]  off1;
    logic [31:0]       data;
    logic [HEAD_W-1:0] head0;
    logic [HEAD_W-1:0] head1;
  } cmd_t;

endpackage

// ===== src/drfw_fifo.sv =====
module drfw_fifo
  import drfw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic full,
  output logic empty
);

  cmd_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [FIFO_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [FIFO_PTR_W:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_cmd = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

endmodule

// ===== src/drfw_front.sv =====
module drfw_front
  import drfw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             action,
  input  logic [LEN_W-1:0] frame_length,
  input  logic [31:0]      ring0_tail,
  input  logic [31:0]      ring1_tail,
  input  logic [7:0]       payload_byte,
  output logic             push,
  output cmd_t             push_cmd
);

  logic [HEAD_W-1:0] head0_r, head0_nxt;
  logic [HEAD_W-1:0] head1_r, head1_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic              adm0_r, adm0_nxt;
  logic              adm1_r, adm1_nxt;

  logic [LEN_W:0]    new_size;
  logic [LEN_W+1:0]  need;
  logic [31:0]       free0, free1;
  logic [LEN_W:0]    cur_size;
  logic [LEN_W-1:0]  idx_inc;
  logic [OFF_W-1:0]  boff0, boff1;

  always_comb begin
    // Frame size: header plus payload, rounded up to a whole word.
    new_size = ({1'b0, frame_length} + (LEN_W+1)'(HEADER_BYTES + ALIGN_ADD))
               & ~(LEN_W+1)'(ALIGN_ADD);
    need     = {1'b0, new_size} + (LEN_W+2)'(ROOM_MARGIN);
    free0    = 32'(RING0_BYTES) - (head0_r - ring0_tail);
    free1    = 32'(RING1_BYTES) - (head1_r - ring1_tail);
    cur_size = ({1'b0, len_r} + (LEN_W+1)'(HEADER_BYTES + ALIGN_ADD))
               & ~(LEN_W+1)'(ALIGN_ADD);
    idx_inc  = idx_r + 1'b1;
    boff0    = (head0_r[OFF_W-1:0] + OFF_W'(HEADER_BYTES) + OFF_W'(idx_r)) & R0_WRAP;
    boff1    = (head1_r[OFF_W-1:0] + OFF_W'(HEADER_BYTES) + OFF_W'(idx_r)) & R1_WRAP;

    head0_nxt = head0_r;
    head1_nxt = head1_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    adm0_nxt  = adm0_r;
    adm1_nxt  = adm1_r;
    push      = 1'b0;

    push_cmd       = '0;
    push_cmd.kind  = CMD_HDR;
    push_cmd.off0  = head0_r[OFF_W-1:0] & R0_WRAP;
    push_cmd.off1  = head1_r[OFF_W-1:0] & R1_WRAP;
    push_cmd.head0 = head0_r;
    push_cmd.head1 = head1_r;

    if (accept) begin
      if (!action) begin
        // A new frame start abandons whatever frame was in progress.
        len_nxt  = frame_length;
        idx_nxt  = '0;
        adm0_nxt = 1'b0;
        adm1_nxt = 1'b0;
        if (frame_length != '0 && free0 > 32'(need)) begin
          adm0_nxt      = 1'b1;
          adm1_nxt      = free1 > 32'(need);
          push          = 1'b1;
          push_cmd.dual = free1 > 32'(need);
          push_cmd.data = 32'(frame_length);
        end
      end else if (adm0_r && idx_r < len_r) begin
        push          = 1'b1;
        push_cmd.kind = CMD_BYTE;
        push_cmd.dual = adm1_r;
        push_cmd.off0 = boff0;
        push_cmd.off1 = boff1;
        push_cmd.data = 32'(payload_byte);
        idx_nxt       = idx_inc;
        if (idx_inc == len_r) begin
          head0_nxt      = head0_r + 32'(cur_size);
          head1_nxt      = adm1_r ? head1_r + 32'(cur_size) : head1_r;
          push_cmd.pub   = 1'b1;
          push_cmd.head0 = head0_r + 32'(cur_size);
          push_cmd.head1 = head1_r + 32'(cur_size);
          adm0_nxt       = 1'b0;
          adm1_nxt       = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head0_r <= '0;
      head1_r <= '0;
      len_r   <= '0;
      idx_r   <= '0;
      adm0_r  <= 1'b0;
      adm1_r  <= 1'b0;
    end else begin
      head0_r <= head0_nxt;
      head1_r <= head1_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      adm0_r  <= adm0_nxt;
      adm1_r  <= adm1_nxt;
    end
  end

endmodule

// ===== src/drfw_back.sv =====
module drfw_back
  import drfw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      magic_word,
  input  logic             q_empty,
  input  cmd_t             q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_result_kind,
  output logic             out_target_ring,
  output logic [OFF_W-1:0] out_byte_offset,
  output logic [31:0]      out_write_data,
  output logic             out_last_of_run
);

  cmd_t             cur_r;
  logic             cur_valid_r, cur_valid_nxt;
  logic [2:0]       step_r, step_nxt;

  logic             out_valid_r, out_valid_nxt;
  rkind_t           kind_r;
  logic             ring_r;
  logic [OFF_W-1:0] off_r;
  logic [31:0]      data_r;
  logic             last_r;

  rkind_t           g_kind;
  logic             g_ring;
  logic [OFF_W-1:0] g_off;
  logic [31:0]      g_data;
  logic             g_last;
  logic             adv;

  always_comb begin
    logic [1:0] k;
    logic [2:0] nb;
    logic [2:0] total;
    logic [2:0] pidx;
    k      = '0;
    nb     = cur_r.dual ? 3'd2 : 3'd1;
    total  = cur_r.pub ? {nb[1:0], 1'b0} : nb;
    pidx   = step_r - nb;
    g_kind = RK_WORD;
    g_ring = 1'b0;
    g_off  = '0;
    g_data = '0;
    g_last = 1'b0;
    case (cur_r.kind)
      CMD_HDR: begin
        k      = cur_r.dual ? step_r[2:1] : step_r[1:0];
        g_ring = cur_r.dual & step_r[0];
        g_kind = RK_WORD;
        g_off  = g_ring ? (cur_r.off1 + OFF_W'({k, 2'b00})) & R1_WRAP
                        : (cur_r.off0 + OFF_W'({k, 2'b00})) & R0_WRAP;
        case (k)
          2'd0:    g_data = magic_word;
          2'd1:    g_data = cur_r.data;
          default: g_data = '0;
        endcase
        g_last = (step_r == (cur_r.dual ? 3'd7 : 3'd3));
      end
      CMD_BYTE: begin
        if (step_r < nb) begin
          g_kind = RK_BYTE;
          g_ring = step_r[0];
          g_off  = step_r[0] ? cur_r.off1 : cur_r.off0;
          g_data = cur_r.data;
        end else begin
          g_kind = RK_PUB;
          g_ring = pidx[0];
          g_off  = '0;
          g_data = pidx[0] ? cur_r.head1 : cur_r.head0;
        end
        g_last = (step_r == total - 3'd1);
      end
      default: begin
        g_last = 1'b1;
      end
    endcase
  end

  assign adv   = cur_valid_r && (!out_valid_r || !out_stall);
  assign q_pop = !q_empty && (!cur_valid_r || (adv && g_last));

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    if (adv) begin
      step_nxt = step_r + 3'd1;
    end
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      step_nxt      = '0;
    end else if (adv && g_last) begin
      cur_valid_nxt = 1'b0;
    end
    out_valid_nxt = adv | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (adv) begin
      kind_r <= g_kind;
      ring_r <= g_ring;
      off_r  <= g_off;
      data_r <= g_data;
      last_r <= g_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_target_ring = ring_r;
  assign out_byte_offset = off_r;
  assign out_write_data  = data_r;
  assign out_last_of_run = last_r;

endmodule

// ===== src/dual_ring_frame_writer_core.sv =====
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+---------------------------------------------
// in_      | input     | in_valid / in_stall | action, frame_length, ring tails, payload_byte
// out_     | output    | out_valid/out_stall | result_kind, target_ring, byte_offset, data, last
// cfg_     | input     | cfg_valid/cfg_ready | cfg_data (magic word)
//
// One input item is taken per cycle whenever the four-entry command queue has room.
// Results leave one per cycle while out_stall is low: a frame start admitted to both rings
// gives eight results, one ring four; a payload byte gives one to four, so the sustained
// rate is set by the result sequencer in the back end.
// Synchronous active-low reset clears the ring heads, frame state, queue and output valid.
// in_stall rises only while the queue is full; out_stall holds the output register.
module dual_ring_frame_writer_core
  import drfw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_action,
  input  logic [LEN_W-1:0] in_frame_length,
  input  logic [31:0]      in_ring0_tail,
  input  logic [31:0]      in_ring1_tail,
  input  logic [7:0]       in_payload_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_result_kind,
  output logic             out_target_ring,
  output logic [OFF_W-1:0] out_byte_offset,
  output logic [31:0]      out_write_data,
  output logic             out_last_of_run,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data
);

  // The magic word register. Writes must arrive only while the block is idle, which the block
  // does not enforce, so that the back end may read it freely while it builds header words.
  logic [31:0] magic_r;

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_in;
  cmd_t q_head;
  logic in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      magic_r <= cfg_data;
    end
  end

  // The front end judges room in the rings, tracks the frame in progress and
  // the producer heads, and turns each productive item into one command.
  drfw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .action       (in_action),
    .frame_length (in_frame_length),
    .ring0_tail   (in_ring0_tail),
    .ring1_tail   (in_ring1_tail),
    .payload_byte (in_payload_byte),
    .push         (q_push),
    .push_cmd     (q_in)
  );

  // The queue lets the front keep taking items while the back is stalled.
  drfw_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .head_cmd (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // The back end expands each command into its run of writes and publishes.
  drfw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .magic_word      (magic_r),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_target_ring (out_target_ring),
    .out_byte_offset (out_byte_offset),
    .out_write_data  (out_write_data),
    .out_last_of_run (out_last_of_run)
  );

  // The front must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command queue overflow");

  // The back must never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command queue underflow");

  // A head publish carries no offset.
  a_pub_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == RK_PUB) |-> (out_byte_offset == '0))
    else $error("head publish with non-zero offset");

  // The publish for ring1 always closes the run of its byte.
  a_pub1_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == RK_PUB && out_target_ring) |-> out_last_of_run)
    else $error("ring1 publish not last of run");

endmodule

// ===== verif/dual_ring_frame_writer_checker.sv =====
`timescale 1ns / 100ps
module dual_ring_frame_writer_checker
  import drfw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             in_action,
  input  logic [LEN_W-1:0] in_frame_length,
  input  logic [31:0]      in_ring0_tail,
  input  logic [31:0]      in_ring1_tail,
  input  logic [7:0]       in_payload_byte,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [1:0]       out_result_kind,
  input  logic             out_target_ring,
  input  logic [OFF_W-1:0] out_byte_offset,
  input  logic [31:0]      out_write_data,
  input  logic             out_last_of_run,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [31:0]      cfg_data,
  output int unsigned      fail_count,
  output int unsigned      pending_count
);

  localparam logic [31:0] ALIGN_MASK = ~32'd3;
  localparam int unsigned REPORT_CAP = 40;

  typedef struct packed {
    rkind_t           kind;
    logic             ring;
    logic [OFF_W-1:0] off;
    logic [31:0]      data;
    logic             last;
  } ring_write_t;

  ring_write_t expected_writes[$];
  ring_write_t run_buf[8];
  int unsigned run_len;

  logic [31:0]       magic = '0;
  logic [HEAD_W-1:0] head0 = '0;
  logic [HEAD_W-1:0] head1 = '0;
  logic [LEN_W-1:0]  open_len = '0;
  logic [LEN_W-1:0]  bytes_seen = '0;
  logic              to_ring0 = 1'b0;
  logic              to_ring1 = 1'b0;
  int unsigned       mismatches = 0;
  int unsigned       results_seen = 0;

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  function automatic logic [OFF_W-1:0] ring_offset(logic ring, logic [31:0] pos);
    return pos[OFF_W-1:0] & (ring ? R1_WRAP : R0_WRAP);
  endfunction

  // Header plus payload, rounded up to whole words.
  function automatic logic [31:0] frame_bytes(logic [LEN_W-1:0] len);
    return (32'(HEADER_BYTES) + 32'(len) + 32'(ALIGN_ADD)) & ALIGN_MASK;
  endfunction

  task automatic add_write(rkind_t kind, logic ring, logic [OFF_W-1:0] off,
                           logic [31:0] data);
    run_buf[run_len] = '{kind: kind, ring: ring, off: off, data: data, last: 1'b0};
    run_len++;
  endtask

  task automatic predict_item();
    logic [31:0] need;
    logic [31:0] room0;
    logic [31:0] room1;
    logic [31:0] word;
    logic [31:0] sz;
    run_len = 0;
    if (in_action == 1'b0) begin
      // A frame start always drops whatever frame was in progress.
      to_ring0 = 1'b0;
      to_ring1 = 1'b0;
      bytes_seen = '0;
      open_len = in_frame_length;
      if (open_len != '0) begin
        need = frame_bytes(open_len) + 32'(ROOM_MARGIN);
        room0 = 32'(RING0_BYTES) - (head0 - in_ring0_tail);
        room1 = 32'(RING1_BYTES) - (head1 - in_ring1_tail);
        if (room0 > need) begin
          to_ring0 = 1'b1;
          to_ring1 = room1 > need;
          for (int k = 0; k < 4; k++) begin
            word = (k == 0) ? magic : (k == 1) ? 32'(open_len) : 32'd0;
            add_write(RK_WORD, 1'b0, ring_offset(1'b0, head0 + 32'(4 * k)), word);
            if (to_ring1) begin
              add_write(RK_WORD, 1'b1, ring_offset(1'b1, head1 + 32'(4 * k)), word);
            end
          end
        end
      end
    end else if (to_ring0 && bytes_seen < open_len) begin
      add_write(RK_BYTE, 1'b0,
                ring_offset(1'b0, head0 + 32'(HEADER_BYTES) + 32'(bytes_seen)),
                32'(in_payload_byte));
      if (to_ring1) begin
        add_write(RK_BYTE, 1'b1,
                  ring_offset(1'b1, head1 + 32'(HEADER_BYTES) + 32'(bytes_seen)),
                  32'(in_payload_byte));
      end
      bytes_seen = bytes_seen + 1'b1;
      if (bytes_seen == open_len) begin
        sz = frame_bytes(open_len);
        head0 = head0 + sz;
        add_write(RK_PUB, 1'b0, '0, head0);
        if (to_ring1) begin
          head1 = head1 + sz;
          add_write(RK_PUB, 1'b1, '0, head1);
        end
        to_ring0 = 1'b0;
        to_ring1 = 1'b0;
      end
    end
    for (int i = 0; i < int'(run_len); i++) begin
      if (i == int'(run_len) - 1) run_buf[i].last = 1'b1;
      expected_writes.push_back(run_buf[i]);
    end
  endtask

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                              results_seen, name, got, want));
    end
  endtask

  always @(posedge clk) begin : watch
    ring_write_t want;
    if (!rst_n) begin
      magic = '0;
      head0 = '0;
      head1 = '0;
      open_len = '0;
      bytes_seen = '0;
      to_ring0 = 1'b0;
      to_ring1 = 1'b0;
      expected_writes.delete();
    end else begin
      if (cfg_valid && cfg_ready) magic = cfg_data;
      if (in_valid && !in_stall) predict_item();
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_writes.pop_front();
          check_field("kind", 32'(out_result_kind), 32'(want.kind));
          check_field("ring", 32'(out_target_ring), 32'(want.ring));
          check_field("offset", 32'(out_byte_offset), 32'(want.off));
          check_field("data", out_write_data, want.data);
          check_field("last", 32'(out_last_of_run), 32'(want.last));
        end
        results_seen++;
      end
    end
    fail_count <= mismatches;
    pending_count <= expected_writes.size();
  end

endmodule

// ===== verif/dual_ring_frame_writer_core_test.sv =====
`timescale 1ns / 100ps
module dual_ring_frame_writer_core_test;
  import drfw_pkg::*;

  // The slowest correct run is a few hundred items, each costing at most eight
  // results, with results held by random stalls and items preceded by random
  // sender gaps, so the limit below leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Items that cause no result never reach the command queue; this pause still
  // follows the last expected result.
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned PHASE_ITEMS = 110;
  localparam logic [31:0] ALIGN_MASK = ~32'd3;

  // How the stimulus places a consumer tail relative to the ring's head.
  typedef enum logic [2:0] {
    ROOM_AMPLE,
    ROOM_ONE_OVER,
    ROOM_EXACT,
    ROOM_SHORT,
    ROOM_AHEAD,
    ROOM_ANY
  } room_mode_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic             in_action;
  logic [LEN_W-1:0] in_frame_length;
  logic [31:0]      in_ring0_tail;
  logic [31:0]      in_ring1_tail;
  logic [7:0]       in_payload_byte;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       out_result_kind;
  logic             out_target_ring;
  logic [OFF_W-1:0] out_byte_offset;
  logic [31:0]      out_write_data;
  logic             out_last_of_run;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [31:0]      cfg_data;
  int unsigned      fail_count;
  int unsigned      pending_count;
  int unsigned      cycle_count = 0;

  // Idling on both sides is switched per phase.
  bit gaps_on = 1'b1;

  // The stimulus keeps its own picture of the ring heads so that it can place
  // tails right on the admission boundary. It tracks only what it has planned;
  // all checking is done by the checker.
  logic [31:0] plan_head0 = '0;
  logic [31:0] plan_head1 = '0;
  logic [15:0] plan_len = '0;
  logic [15:0] plan_sent = '0;
  logic        plan_open = 1'b0;
  logic        plan_dual = 1'b0;
  int unsigned busy_items = 0;

  dual_ring_frame_writer_core u_dut (.*);

  dual_ring_frame_writer_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is cut short at the limit, which only a hung block can reach.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The result side stalls in random bursts while idling is on.
  initial begin
    forever begin
      @(posedge clk);
      if (gaps_on && rst_n && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [31:0] frame_size(logic [15:0] len);
    return (32'(HEADER_BYTES) + 32'(len) + 32'(ALIGN_ADD)) & ALIGN_MASK;
  endfunction

  function automatic logic ring_has_room(logic ring, logic [31:0] tail, logic [31:0] need);
    logic [31:0] h;
    logic [31:0] size;
    h = ring ? plan_head1 : plan_head0;
    size = ring ? 32'(RING1_BYTES) : 32'(RING0_BYTES);
    return (size - (h - tail)) > need;
  endfunction

  // Free space is ring size minus (head - tail), so the tail is chosen to set
  // the free space against the need of the frame.
  function automatic logic [31:0] pick_tail(logic ring, logic [15:0] len, room_mode_t mode);
    logic [31:0] h;
    logic [31:0] size;
    logic [31:0] need;
    h = ring ? plan_head1 : plan_head0;
    size = ring ? 32'(RING1_BYTES) : 32'(RING0_BYTES);
    need = frame_size(len) + 32'(ROOM_MARGIN);
    case (mode)
      ROOM_AMPLE:    return h - 32'($urandom_range(0, 4096));
      ROOM_ONE_OVER: return h - (size - need - 32'd1);
      ROOM_EXACT:    return h - (size - need);
      ROOM_SHORT:    return h - (size - need) - 32'($urandom_range(1, 256));
      ROOM_AHEAD:    return h + 32'($urandom_range(1, 32'h7FFF_FFFF));
      default:       return $urandom();
    endcase
  endfunction

  function automatic room_mode_t pick_mode();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return ROOM_AMPLE;
    if (roll < 65) return ROOM_ONE_OVER;
    if (roll < 72) return ROOM_EXACT;
    if (roll < 80) return ROOM_SHORT;
    if (roll < 90) return ROOM_AHEAD;
    return ROOM_ANY;
  endfunction

  // Presents one item and holds it until the block takes it. A gap, when one is
  // drawn, lowers valid in this step and raises it again only in a later one.
  task automatic push_item(logic action, logic [15:0] len, logic [31:0] t0,
                           logic [31:0] t1, logic [7:0] b);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_frame_length <= len;
    in_ring0_tail <= t0;
    in_ring1_tail <= t1;
    in_payload_byte <= b;
    do @(posedge clk); while (in_stall);
    busy_items++;
  endtask

  // The byte field carries noise on a frame start, as the block must ignore it.
  task automatic start_frame(logic [15:0] len, logic [31:0] t0, logic [31:0] t1);
    logic [31:0] need;
    need = frame_size(len) + 32'(ROOM_MARGIN);
    plan_len = len;
    plan_sent = '0;
    plan_open = (len != '0) && ring_has_room(1'b0, t0, need);
    plan_dual = plan_open && ring_has_room(1'b1, t1, need);
    push_item(1'b0, len, t0, t1, 8'($urandom));
  endtask

  // Likewise the length and tails carry noise on a payload byte.
  task automatic send_byte(logic [7:0] b);
    logic [31:0] sz;
    push_item(1'b1, 16'($urandom), $urandom(), $urandom(), b);
    if (plan_open) begin
      plan_sent++;
      if (plan_sent == plan_len) begin
        sz = frame_size(plan_len);
        plan_head0 += sz;
        if (plan_dual) plan_head1 += sz;
        plan_open = 1'b0;
      end
    end
  endtask

  task automatic write_magic(logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every expected result has come out, then lets the queue empty.
  // The first edge lets the checker count the item taken in this step.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly complete frames of a few bytes, with now and then a longer one, an
  // empty one, a frame cut short by the next start, or stray bytes after the
  // end. Tails land on every side of the admission boundary.
  task automatic random_frame();
    int unsigned choice;
    int unsigned nbytes;
    logic [15:0] len;
    choice = $urandom_range(0, 99);
    if (choice < 5) len = '0;
    else if ($urandom_range(0, 15) == 0) len = 16'($urandom_range(9, 48));
    else len = 16'($urandom_range(1, 8));
    start_frame(len, pick_tail(1'b0, len, pick_mode()), pick_tail(1'b1, len, pick_mode()));
    if (choice < 82) nbytes = len;
    else if (choice < 92) nbytes = $urandom_range(0, len);
    else nbytes = len + $urandom_range(1, 3);
    repeat (nbytes) send_byte(8'($urandom));
  endtask

  initial begin
    in_valid = 1'b0;
    in_action = 1'b0;
    in_frame_length = '0;
    in_ring0_tail = '0;
    in_ring1_tail = '0;
    in_payload_byte = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_magic(32'hFFFF_FFFF);

    // A byte with no frame open, then an empty frame; neither gives results.
    send_byte(8'h00);
    start_frame(16'd0, 32'd0, 32'd0);
    // The longest frame, admitted to both rings with one byte to spare, is
    // left unfinished and then abandoned by the next start.
    start_frame(16'hFFFF, pick_tail(1'b0, 16'hFFFF, ROOM_ONE_OVER),
                pick_tail(1'b1, 16'hFFFF, ROOM_ONE_OVER));
    send_byte(8'hFF);
    send_byte(8'h00);
    // Free space equal to the need is not enough; the byte is dropped too.
    start_frame(16'd1, pick_tail(1'b0, 16'd1, ROOM_EXACT), pick_tail(1'b1, 16'd1, ROOM_AMPLE));
    send_byte(8'h5A);
    // Ring0 only, with ring1 exactly at the boundary.
    start_frame(16'd1, pick_tail(1'b0, 16'd1, ROOM_ONE_OVER),
                pick_tail(1'b1, 16'd1, ROOM_EXACT));
    send_byte(8'hFF);
    // Tails ahead of the heads look like plenty of room.
    start_frame(16'd3, pick_tail(1'b0, 16'd3, ROOM_AHEAD), pick_tail(1'b1, 16'd3, ROOM_AHEAD));
    repeat (3) send_byte(8'($urandom));
    start_frame(16'd2, pick_tail(1'b0, 16'd2, ROOM_AMPLE), pick_tail(1'b1, 16'd2, ROOM_SHORT));
    repeat (2) send_byte(8'($urandom));
    start_frame(16'd4, pick_tail(1'b0, 16'd4, ROOM_SHORT), pick_tail(1'b1, 16'd4, ROOM_AMPLE));
    // An empty frame start abandons a frame in progress.
    start_frame(16'd5, pick_tail(1'b0, 16'd5, ROOM_AMPLE), pick_tail(1'b1, 16'd5, ROOM_AMPLE));
    repeat (2) send_byte(8'($urandom));
    start_frame(16'd0, $urandom(), $urandom());
    send_byte(8'($urandom));
    // Tails at the extremes of their range.
    start_frame(16'd2, 32'hFFFF_FFFF, 32'h0000_0000);
    repeat (2) send_byte(8'($urandom));
    settle();

    // Random phases, each under its own magic word. The second phase runs
    // without idling, as does the last part of the run.
    for (int phase = 0; phase < 4; phase++) begin
      gaps_on = (phase == 0 || phase == 2);
      case (phase)
        0:       write_magic(32'h0000_0000);
        3:       write_magic(32'hFFFF_FFFF);
        default: write_magic($urandom());
      endcase
      busy_items = 0;
      while (busy_items < PHASE_ITEMS) random_frame();
      settle();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== dual_ring_frame_writer_core.f =====
src/drfw_pkg.sv
src/drfw_fifo.sv
src/drfw_front.sv
src/drfw_back.sv
src/dual_ring_frame_writer_core.sv
verif/dual_ring_frame_writer_checker.sv
verif/dual_ring_frame_writer_core_test.sv
